FILE: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// Package for the stream find-and-replace block: sizes, register indexes,
// the control and status structs of the window row, and length helpers.
// No dependencies.
package sfr_pkg;

    localparam int PATTERN_MAX     = 8;
    localparam int REPLACEMENT_MAX = 8;
    localparam int BYTE_W          = 8;
    localparam int REG_W           = 64;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = $clog2(PATTERN_MAX + 1);
    localparam int WIN_IDX_W       = $clog2(PATTERN_MAX);
    localparam int REPL_IDX_W      = $clog2(REPLACEMENT_MAX);
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 shift;
        logic [WIN_IDX_W-1:0] load_idx;
        logic [CNT_W-1:0]     count;
    } t_win_ctrl;

    typedef struct packed {
        logic [BYTE_W-1:0] front_byte;
        logic              all_ok;
    } t_win_stat;

    function automatic logic [CNT_W-1:0] eff_plen(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] res;
        if (len == '0) begin
            res = CNT_W'(1);
        end else if (len > LEN_W'(PATTERN_MAX)) begin
            res = CNT_W'(PATTERN_MAX);
        end else begin
            res = CNT_W'(len);
        end
        return res;
    endfunction

    function automatic logic [REPL_IDX_W:0] eff_rlen(input logic [LEN_W-1:0] len);
        logic [REPL_IDX_W:0] res;
        if (len > LEN_W'(REPLACEMENT_MAX)) begin
            res = (REPL_IDX_W + 1)'(REPLACEMENT_MAX);
        end else begin
            res = (REPL_IDX_W + 1)'(len);
        end
        return res;
    endfunction

endpackage

FILE: rtl/sfr_cell.sv
`timescale 1ns / 1ps
// One cell of the match window: holds one byte, compares it with its
// pattern byte and takes its neighbor's byte when the window shifts.
// Depends on sfr_pkg.
module sfr_cell
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic [BYTE_W-1:0] i_next_byte,
    input  logic [BYTE_W-1:0] i_pat_byte,
    input  logic              i_occupied,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_ok
);

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_text_byte;
        end else if (i_shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = !i_occupied || (r_byte == i_pat_byte);

endmodule

FILE: rtl/sfr_window.sv
`timescale 1ns / 1ps
// Row of window cells that shifts toward the front and reports whether the
// held bytes form a prefix of the pattern.
// Depends on sfr_pkg and sfr_cell.
module sfr_window
    import sfr_pkg::*;
(
    input  logic             i_clk,
    input  t_win_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic [REG_W-1:0] i_pattern_bytes,
    output t_win_stat        o_stat
);

    logic [BYTE_W-1:0]      cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic [BYTE_W-1:0] next_byte;

        if (g == PATTERN_MAX - 1) begin : g_tail
            assign next_byte = '0;
        end else begin : g_body
            assign next_byte = cell_byte[g+1];
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctrl.load && (i_ctrl.load_idx == WIN_IDX_W'(g))),
            .i_shift     (i_ctrl.shift),
            .i_text_byte (i_text_byte),
            .i_next_byte (next_byte),
            .i_pat_byte  (i_pattern_bytes[g*BYTE_W +: BYTE_W]),
            .i_occupied  (i_ctrl.count > CNT_W'(g)),
            .o_byte      (cell_byte[g]),
            .o_ok        (cell_ok[g])
        );
    end

    assign o_stat.front_byte = cell_byte[0];
    assign o_stat.all_ok     = &cell_ok;

endmodule

FILE: rtl/sfr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the find-and-replace block: drives the window row, emits
// one byte per cycle unless the output stalls, through a one-byte hold stage,
// and owns the output register. Depends on sfr_pkg.
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_text_end,
    input  logic [CNT_W-1:0]    i_plen,
    input  logic [REPL_IDX_W:0] i_rlen,
    input  logic [REG_W-1:0]    i_repl_bytes,
    output t_win_ctrl           o_win,
    input  t_win_stat           i_win,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_byte_present,
    output logic                o_run_last,
    output logic                o_text_done
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_REPL  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_end, n_end;
    logic [REPL_IDX_W-1:0] r_ridx, n_ridx;
    logic                r_hold_valid, n_hold_valid;
    logic [BYTE_W-1:0]   r_hold_byte, n_hold_byte;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_present, n_out_present;
    logic                r_out_last, n_out_last;
    logic                r_out_done, n_out_done;

    logic                push_ok;
    logic                hold_block;
    logic                prefix;
    logic                emit_req;
    logic [BYTE_W-1:0]   emit_byte;
    logic [WIN_IDX_W-1:0] load_idx;

    assign push_ok    = !r_out_valid || i_out_ready;
    assign hold_block = r_hold_valid && !push_ok;
    assign prefix     = (r_count <= i_plen) && i_win.all_ok;
    assign load_idx   = (r_count >= CNT_W'(PATTERN_MAX)) ?
                        WIN_IDX_W'(PATTERN_MAX - 1) : r_count[WIN_IDX_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_end         = r_end;
        n_ridx        = r_ridx;
        n_hold_valid  = r_hold_valid;
        n_hold_byte   = r_hold_byte;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_byte    = r_out_byte;
        n_out_present = r_out_present;
        n_out_last    = r_out_last;
        n_out_done    = r_out_done;
        emit_req      = 1'b0;
        emit_byte     = i_win.front_byte;
        o_in_ready    = 1'b0;
        o_win.load     = 1'b0;
        o_win.shift    = 1'b0;
        o_win.load_idx = load_idx;
        o_win.count    = r_count;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_win.load = 1'b1;
                    n_count    = CNT_W'(load_idx) + CNT_W'(1);
                    n_end      = i_text_end;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_count != '0) && !prefix) begin
                    emit_req = 1'b1;
                    if (!hold_block) begin
                        o_win.shift = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                    end
                end else if (r_count == i_plen) begin
                    n_count = '0;
                    n_ridx  = '0;
                    n_state = (i_rlen != '0) ? S_REPL : S_DONE;
                end else begin
                    n_state = r_end ? S_FLUSH : S_DONE;
                end
            end
            S_REPL: begin
                emit_req  = 1'b1;
                emit_byte = i_repl_bytes[{r_ridx, 3'b000} +: BYTE_W];
                if (!hold_block) begin
                    n_ridx = r_ridx + REPL_IDX_W'(1);
                    if (({1'b0, r_ridx} + (REPL_IDX_W + 1)'(1)) == i_rlen) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                if (r_count != '0) begin
                    emit_req = 1'b1;
                    if (!hold_block) begin
                        o_win.shift = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_hold_valid || r_end) begin
                    if (push_ok) begin
                        n_out_valid   = 1'b1;
                        n_out_byte    = r_hold_valid ? r_hold_byte : '0;
                        n_out_present = r_hold_valid;
                        n_out_last    = 1'b1;
                        n_out_done    = r_end;
                        n_hold_valid  = 1'b0;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit_req && !hold_block) begin
            if (r_hold_valid) begin
                n_out_valid   = 1'b1;
                n_out_byte    = r_hold_byte;
                n_out_present = 1'b1;
                n_out_last    = 1'b0;
                n_out_done    = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_byte  = emit_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_end        <= 1'b0;
            r_ridx       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_end        <= n_end;
            r_ridx       <= n_ridx;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_byte   <= n_hold_byte;
        r_out_byte    <= n_out_byte;
        r_out_present <= n_out_present;
        r_out_last    <= n_out_last;
        r_out_done    <= n_out_done;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_present = r_out_present;
    assign o_run_last     = r_out_last;
    assign o_text_done    = r_out_done;

endmodule

FILE: rtl/stream_find_replace_top.sv
`timescale 1ns / 1ps
// Top level of the stream find-and-replace block: configuration registers,
// the window row and the sequencer.
// Depends on sfr_pkg, sfr_window and sfr_ctrl.
//
// The block rewrites a byte stream, replacing every leftmost, non-overlapping
// occurrence of a pattern of 1 to 8 bytes with a replacement of 0 to 8 bytes.
// One text byte is taken at a time; an end-of-text byte that ends without a
// match flushes the window. The sequencer emits one result per cycle, unless
// output backpressure stalls it, from the front of the cell row or from the
// replacement register. A finished result waits in the output register while
// the next byte is taken. A result with byte_present low is an end marker for
// a final text byte that produced no bytes. Configuration must be written
// only while idle; the block itself does not enforce this.
module stream_find_replace_top
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_text_byte,
    input  logic                 i_text_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_byte_present,
    output logic                 o_run_last,
    output logic                 o_text_done
);

    logic [LEN_W-1:0] r_pattern_length;
    logic [REG_W-1:0] r_pattern_bytes;
    logic [LEN_W-1:0] r_replacement_length;
    logic [REG_W-1:0] r_replacement_bytes;

    t_win_ctrl win_ctrl;
    t_win_stat win_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length     <= LEN_W'(1);
            r_pattern_bytes      <= '0;
            r_replacement_length <= '0;
            r_replacement_bytes  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH:     r_pattern_length     <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_BYTES:      r_pattern_bytes      <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_replacement_length <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_replacement_bytes  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfr_window u_window (
        .i_clk           (i_clk),
        .i_ctrl          (win_ctrl),
        .i_text_byte     (i_text_byte),
        .i_pattern_bytes (r_pattern_bytes),
        .o_stat          (win_stat)
    );

    sfr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_end     (i_text_end),
        .i_plen         (eff_plen(r_pattern_length)),
        .i_rlen         (eff_rlen(r_replacement_length)),
        .i_repl_bytes   (r_replacement_bytes),
        .o_win          (win_ctrl),
        .i_win          (win_stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_text_done    (o_text_done)
    );

endmodule

FILE: rtl/sfr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the stream find-and-replace block, bound to the
// top level.
// Depends on sfr_pkg and stream_find_replace_top.
module sfr_checker
    import sfr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [BYTE_W-1:0]    o_out_byte,
    input logic                 o_byte_present,
    input logic                 o_run_last,
    input logic                 o_text_done
);

    // A stalled output transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_byte_present) && $stable(o_run_last) && $stable(o_text_done))
        else $error("output payload changed while stalled");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_present |-> o_run_last && o_text_done)
        else $error("end marker without run_last and text_done");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_done |-> o_run_last)
        else $error("text_done without run_last");

    // Each input transfer is worked on alone, so ready drops right after it.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while previous byte still in work");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for stream_find_replace_top: a directed table followed by
// random texts, checked against a built-in find-and-replace predictor or typed results.
// Depends on sfr_pkg and the RTL of stream_find_replace_top.
module tb_top
    import sfr_pkg::*;
();

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_ITEMS     = 356;
    localparam int QUIET_TAIL_ITEMS = 60;
    localparam int SETTLE_CYCLES    = 20;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_MAX       = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              present;
        logic              last;
        logic              done;
    } t_out_rec;

    typedef enum logic {ROW_WRITE, ROW_TEXT} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     value;
        logic [BYTE_W-1:0]    text_b;
        logic                 text_e;
        bit                   typed;
        t_out_rec             rec;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_text_byte;
    logic                 i_text_end;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_byte_present;
    logic                 o_run_last;
    logic                 o_text_done;

    stream_find_replace_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_text_end     (i_text_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_text_done    (o_text_done)
    );

    logic [LEN_W-1:0]  pat_len_reg = LEN_W'(1);
    logic [REG_W-1:0]  pat_reg     = '0;
    logic [LEN_W-1:0]  rep_len_reg = '0;
    logic [REG_W-1:0]  rep_reg     = '0;
    logic [BYTE_W-1:0] win [PATTERN_MAX];
    int                win_cnt     = 0;

    t_out_rec  step_out[$];
    t_out_rec  rewritten_q[$];
    t_plan_row plan[$];

    logic [BYTE_W-1:0] alpha_base;
    bit  idle_on       = 1'b1;
    bit  long_hold_req = 1'b0;
    int  fault_count   = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    int  phase_count   = 0;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rewritten_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pattern_span();
        int span;
        span = int'(pat_len_reg);
        if (span < 1) span = 1;
        if (span > PATTERN_MAX) span = PATTERN_MAX;
        return span;
    endfunction

    function automatic bit window_fits(input int span);
        if (win_cnt > span) return 1'b0;
        for (int i = 0; i < win_cnt; i++) begin
            if (win[i] != pat_reg[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the results of one text byte and advances the window.
    task automatic rewrite_byte(input logic [BYTE_W-1:0] b, input logic e);
        int       span;
        int       rspan;
        t_out_rec rec;
        span  = pattern_span();
        rspan = (int'(rep_len_reg) > REPLACEMENT_MAX) ? REPLACEMENT_MAX : int'(rep_len_reg);
        step_out.delete();
        if (win_cnt >= PATTERN_MAX) win_cnt = PATTERN_MAX - 1;
        win[win_cnt] = b;
        win_cnt++;
        while (win_cnt > 0 && !window_fits(span)) begin
            step_out.push_back('{win[0], 1'b1, 1'b0, 1'b0});
            for (int i = 0; i < PATTERN_MAX - 1; i++) win[i] = win[i+1];
            win_cnt--;
        end
        if (win_cnt == span) begin
            for (int i = 0; i < rspan; i++) begin
                step_out.push_back('{rep_reg[8*i +: 8], 1'b1, 1'b0, 1'b0});
            end
            win_cnt = 0;
        end
        if (e) begin
            for (int i = 0; i < win_cnt; i++) step_out.push_back('{win[i], 1'b1, 1'b0, 1'b0});
            win_cnt = 0;
            if (step_out.size() == 0) begin
                step_out.push_back('{'0, 1'b0, 1'b1, 1'b1});
            end else begin
                rec = step_out[step_out.size()-1];
                rec.done = 1'b1;
                step_out[step_out.size()-1] = rec;
            end
        end
        if (step_out.size() > 0) begin
            rec = step_out[step_out.size()-1];
            rec.last = 1'b1;
            step_out[step_out.size()-1] = rec;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH:     pat_len_reg = value[LEN_W-1:0];
            CFG_PATTERN_BYTES:      pat_reg     = value;
            CFG_REPLACEMENT_LENGTH: rep_len_reg = value[LEN_W-1:0];
            CFG_REPLACEMENT_BYTES:  rep_reg     = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e,
                             input bit typed, input t_out_rec typed_rec);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_text_end  <= e;
        do @(posedge i_clk); while (!o_in_ready);
        rewrite_byte(b, e);
        if (typed) begin
            rewritten_q.push_back(typed_rec);
        end else begin
            foreach (step_out[k]) rewritten_q.push_back(step_out[k]);
        end
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        plan.push_back('{ROW_WRITE, idx, value, '0, 1'b0, 1'b0, '0});
    endtask

    task automatic add_text(input logic [BYTE_W-1:0] b, input logic e,
                            input bit typed, input t_out_rec rec);
        plan.push_back('{ROW_TEXT, '0, '0, b, e, typed, rec});
    endtask

    task automatic pick_settings(input bit full);
        logic [REG_W-1:0] pbytes;
        logic [LEN_W-1:0] plen_v;
        logic [LEN_W-1:0] rlen_v;
        alpha_base = BYTE_W'($urandom());
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                pbytes[8*k +: 8] = BYTE_W'($urandom());
            end else begin
                pbytes[8*k +: 8] = alpha_base + BYTE_W'($urandom_range(0, 2));
            end
        end
        case ($urandom_range(0, 9))
            0: plen_v = '0;
            1: plen_v = LEN_W'($urandom_range(PATTERN_MAX + 1, 15));
            2: plen_v = LEN_W'(PATTERN_MAX);
            3: plen_v = LEN_W'(1);
            default: plen_v = LEN_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0: rlen_v = '0;
            1: rlen_v = LEN_W'($urandom_range(REPLACEMENT_MAX + 1, 15));
            2: rlen_v = LEN_W'(REPLACEMENT_MAX);
            default: rlen_v = LEN_W'($urandom_range(0, REPLACEMENT_MAX));
        endcase
        if (full || $urandom_range(0, 1) == 0) write_reg(CFG_PATTERN_LENGTH, REG_W'(plen_v));
        if (full || $urandom_range(0, 1) == 0) write_reg(CFG_PATTERN_BYTES, pbytes);
        if (full || $urandom_range(0, 1) == 0) write_reg(CFG_REPLACEMENT_LENGTH, REG_W'(rlen_v));
        if (full || $urandom_range(0, 1) == 0) begin
            write_reg(CFG_REPLACEMENT_BYTES, {$urandom(), $urandom()});
        end
    endtask

    // Texts are built mostly from whole or partial pattern copies so that
    // matches, near misses and window releases happen often.
    task automatic run_phase(input int n_items);
        logic [BYTE_W-1:0] chunk[$];
        int                pick;
        int                span;
        int                plen_part;
        int                text_left;
        int                sent;
        logic              last_flag;
        text_left = $urandom_range(1, 24);
        sent      = 0;
        span      = pattern_span();
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            chunk.delete();
            if (pick < 5) begin
                for (int i = 0; i < span; i++) chunk.push_back(pat_reg[8*i +: 8]);
            end else if (pick < 7) begin
                plen_part = $urandom_range(1, span);
                for (int i = 0; i < plen_part; i++) chunk.push_back(pat_reg[8*i +: 8]);
            end else if (pick < 9) begin
                chunk.push_back(alpha_base + BYTE_W'($urandom_range(0, 2)));
            end else begin
                chunk.push_back(BYTE_W'($urandom()));
            end
            foreach (chunk[k]) begin
                if (sent < n_items) begin
                    text_left--;
                    last_flag = (text_left == 0);
                    send_byte(chunk[k], last_flag, 1'b0, '0);
                    if (last_flag) text_left = $urandom_range(1, 24);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : out_check
        t_out_rec got;
        t_out_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_byte, o_byte_present, o_run_last, o_text_done};
            results_seen++;
            if (rewritten_q.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("unexpected result: byte %02h present %0b last %0b done %0b",
                             got.byte_val, got.present, got.last, got.done);
                end
            end else begin
                want = rewritten_q.pop_front();
                if (got.byte_val !== want.byte_val || got.present !== want.present ||
                    got.last !== want.last || got.done !== want.done) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display({"mismatch at result %0d: expected %02h/%0b/%0b/%0b, ",
                                  "got %02h/%0b/%0b/%0b"},
                                 results_seen, want.byte_val, want.present, want.last,
                                 want.done, got.byte_val, got.present, got.last, got.done);
                    end
                end
            end
        end
    end

    initial begin : rx_side
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : tx_side
        int directed_items;
        int remaining;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_text_byte = '0;
        i_text_end  = 1'b0;

        add_text(8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0});
        add_text(8'h00, 1'b0, 1'b0, '0);
        add_text(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1});
        add_text(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1});
        add_write(CFG_PATTERN_LENGTH, 64'd3);
        add_write(CFG_PATTERN_BYTES, 64'h636261);
        add_write(CFG_REPLACEMENT_LENGTH, 64'd2);
        add_write(CFG_REPLACEMENT_BYTES, 64'h5958);
        add_text(8'h61, 1'b0, 1'b0, '0);
        add_text(8'h62, 1'b0, 1'b0, '0);
        add_text(8'h63, 1'b0, 1'b0, '0);
        add_text(8'h61, 1'b0, 1'b0, '0);
        add_text(8'h62, 1'b0, 1'b0, '0);
        add_text(8'h61, 1'b0, 1'b0, '0);
        add_text(8'h62, 1'b0, 1'b0, '0);
        add_text(8'h63, 1'b0, 1'b0, '0);
        add_text(8'h61, 1'b0, 1'b0, '0);
        add_text(8'h62, 1'b1, 1'b0, '0);
        add_write(CFG_PATTERN_LENGTH, 64'd0);
        add_write(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(CFG_REPLACEMENT_LENGTH, 64'd15);
        add_write(CFG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        add_text(8'hFF, 1'b0, 1'b0, '0);
        add_text(8'hFF, 1'b1, 1'b0, '0);
        add_write(CFG_PATTERN_LENGTH, 64'd15);
        add_write(CFG_PATTERN_BYTES, 64'hFEDC_BA98_7654_3210);
        add_write(CFG_REPLACEMENT_LENGTH, 64'd0);
        add_text(8'h10, 1'b0, 1'b0, '0);
        add_text(8'h32, 1'b0, 1'b0, '0);
        add_text(8'h54, 1'b0, 1'b0, '0);
        add_text(8'h76, 1'b0, 1'b0, '0);
        add_text(8'h98, 1'b0, 1'b0, '0);
        add_text(8'hBA, 1'b0, 1'b0, '0);
        add_text(8'hDC, 1'b0, 1'b0, '0);
        add_text(8'hFE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[r].idx, plan[r].value);
            end else begin
                send_byte(plan[r].text_b, plan[r].text_e, plan[r].typed, plan[r].rec);
            end
        end
        settle();
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            remaining = directed_items + RANDOM_ITEMS - items_sent;
            idle_on   = (remaining > QUIET_TAIL_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
            pick_settings(phase_count == 0 || $urandom_range(0, 2) == 0);
            if (phase_count == 2) long_hold_req = 1'b1;
            run_phase((remaining < 40) ? remaining : $urandom_range(15, 40));
            settle();
            phase_count++;
        end

        $display("covered %0d text bytes (%0d directed) over %0d register settings",
                 items_sent, directed_items, phase_count + 4);
        $display("checked %0d results, %0d mismatches", results_seen, fault_count);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
